[src/eafr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Escaped API frame receiver package
// Shared types and constants for the frame receiver: the parser state, the
// result record and the event codes.
// ----------------------------------------------------------------------------
package eafr_pkg;

    // Framing bytes and checksum constants.
    localparam logic [7:0] START_MARK  = 8'h7E;
    localparam logic [7:0] ESCAPE_MARK = 8'h7D;
    localparam logic [7:0] ESCAPE_FLIP = 8'h20;
    localparam logic [7:0] SUM_GOOD    = 8'hFF;
    localparam logic [7:0] RX_TYPE_RST = 8'h90;

    // Position codes within a frame; payload starts at POS_PAYLOAD.
    localparam int unsigned POS_W       = 17;
    localparam logic [POS_W-1:0] POS_HUNT    = 17'd0;
    localparam logic [POS_W-1:0] POS_LEN_HI  = 17'd1;
    localparam logic [POS_W-1:0] POS_LEN_LO  = 17'd2;
    localparam logic [POS_W-1:0] POS_TYPE    = 17'd3;
    localparam logic [POS_W-1:0] POS_PAYLOAD = 17'd4;

    // Event reported with each result.
    typedef enum logic [2:0] {
        EV_PAYLOAD        = 3'd0,
        EV_GOOD           = 3'd1,
        EV_BAD_SUM        = 3'd2,
        EV_START_IN_FRAME = 3'd3,
        EV_ZERO_LENGTH    = 3'd4
    } t_event;

    // Parser state carried from one byte to the next.
    typedef struct packed {
        logic [POS_W-1:0] position;
        logic [15:0]      frame_length;
        logic [7:0]       running_sum;
        logic             escape_pending;
        logic [7:0]       current_type;
    } t_state;

    // One result record.
    typedef struct packed {
        t_event      event_res;
        logic [7:0]  data_byte;
        logic [15:0] byte_index;
        logic [7:0]  frame_type;
        logic        is_receive_packet;
    } t_result;

endpackage

[src/eafr_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Escaped API frame receiver step logic
// Combinational update of the parser state for one raw byte, together with
// the result that the byte produces, if any.
// ----------------------------------------------------------------------------
module eafr_step
    import eafr_pkg::*;
(
    input  t_state       i_state,
    input  logic [7:0]   i_raw,
    input  logic [7:0]   i_rx_type,
    output t_state       o_state,
    output logic         o_res_valid,
    output t_result      o_res
);

    logic [7:0]       w_byte;
    logic             w_take;
    logic [7:0]       w_sum;
    logic [POS_W-1:0] w_end_pos;
    logic [POS_W-1:0] w_index;

    // Running sum including this byte, and the checksum position.
    assign w_sum     = i_state.running_sum + w_byte;
    assign w_end_pos = {1'b0, i_state.frame_length} + POS_TYPE;
    assign w_index   = i_state.position - POS_PAYLOAD;

    // Unescape the byte and decide whether it carries data.
    always_comb begin
        w_byte = i_raw;
        w_take = 1'b0;
        if (i_state.position != POS_HUNT && i_raw != START_MARK) begin
            if (i_state.escape_pending) begin
                w_byte = i_raw ^ ESCAPE_FLIP;
                w_take = 1'b1;
            end else if (i_raw != ESCAPE_MARK) begin
                w_take = 1'b1;
            end
        end
    end

    // State update and result selection.
    always_comb begin
        o_state     = i_state;
        o_res_valid = 1'b0;
        o_res       = '{event_res: EV_PAYLOAD, data_byte: 8'h00, byte_index: 16'h0000,
                        frame_type: i_state.current_type, is_receive_packet: 1'b0};

        if (i_state.position == POS_HUNT) begin
            // Hunting: only a start byte matters.
            if (i_raw == START_MARK) begin
                o_state.position       = POS_LEN_HI;
                o_state.running_sum    = 8'h00;
                o_state.escape_pending = 1'b0;
                o_state.current_type   = 8'h00;
            end
        end else if (i_raw == START_MARK) begin
            // A start byte inside a frame abandons it and opens a new one.
            o_res_valid            = 1'b1;
            o_res.event_res        = EV_START_IN_FRAME;
            o_state.position       = POS_LEN_HI;
            o_state.running_sum    = 8'h00;
            o_state.escape_pending = 1'b0;
            o_state.current_type   = 8'h00;
        end else if (!w_take) begin
            // Escape byte: the next raw byte is flipped.
            o_state.escape_pending = 1'b1;
        end else begin
            o_state.escape_pending = 1'b0;
            case (i_state.position)
                POS_LEN_HI: begin
                    o_state.frame_length = {w_byte, 8'h00};
                    o_state.position     = POS_LEN_LO;
                end
                POS_LEN_LO: begin
                    o_state.frame_length = {i_state.frame_length[15:8], w_byte};
                    if ({i_state.frame_length[15:8], w_byte} == 16'h0000) begin
                        o_state.position = POS_HUNT;
                        o_res_valid      = 1'b1;
                        o_res.event_res  = EV_ZERO_LENGTH;
                    end else begin
                        o_state.position = POS_TYPE;
                    end
                end
                POS_TYPE: begin
                    o_state.current_type = w_byte;
                    o_state.running_sum  = w_byte;
                    o_state.position     = POS_PAYLOAD;
                end
                default: begin
                    o_state.running_sum = w_sum;
                    o_res_valid         = 1'b1;
                    if (i_state.position >= w_end_pos) begin
                        // Checksum byte closes the frame.
                        o_state.position = POS_HUNT;
                        if (w_sum == SUM_GOOD) begin
                            o_res.event_res         = EV_GOOD;
                            o_res.is_receive_packet = (i_state.current_type == i_rx_type);
                        end else begin
                            o_res.event_res = EV_BAD_SUM;
                        end
                    end else begin
                        o_res.event_res  = EV_PAYLOAD;
                        o_res.data_byte  = w_byte;
                        o_res.byte_index = w_index[15:0];
                        o_state.position = i_state.position + 17'd1;
                    end
                end
            endcase
        end
    end

endmodule

[src/escaped_api_frame_receiver_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Escaped API frame receiver
// Parses escaped API frames from a raw byte stream and reports payload bytes
// and frame status events.
// ----------------------------------------------------------------------------
// The receiver takes one raw serial byte per clock cycle and produces at most
// one result per byte, in the cycle after the byte transfer. The whole state
// update for a byte is a combinational step, so a new byte is accepted every
// cycle while the output register is empty or being drained; only a stalled
// output holds up the input. Bytes before a start mark produce no result.
// The receive frame type register resets to 0x90 and is written by a single
// write enable; write it only while the receiver is idle.
// ----------------------------------------------------------------------------
module escaped_api_frame_receiver_core
    import eafr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: receive_frame_type.
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data,
    // Input stream.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] rx_byte
    // Output stream.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [7:0] data_byte, [23:8] byte_index,
                                          // [31:24] frame_type
    output logic [3:0]  o_m_axis_tuser    // [2:0] event_res, [3] is_receive_packet
);

    t_state     r_state;
    t_state     n_state;
    logic [7:0] r_rx_type;
    logic       r_out_valid;
    t_result    r_out;
    logic       w_res_valid;
    t_result    w_res;
    logic       w_in_xfer;

    // Input is taken whenever the output register can take a result.
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign w_in_xfer       = i_s_axis_tvalid && o_s_axis_tready;

    eafr_step u_step (
        .i_state     (r_state),
        .i_raw       (i_s_axis_tdata),
        .i_rx_type   (r_rx_type),
        .o_state     (n_state),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_type <= RX_TYPE_RST;
        end else if (i_cfg_wr_en) begin
            r_rx_type <= i_cfg_wr_data;
        end
    end

    // Parser state advances on each input transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (w_in_xfer) begin
            r_state <= n_state;
        end
    end

    // Output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_out_valid <= w_in_xfer && w_res_valid;
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready) begin
            r_out <= w_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out.frame_type, r_out.byte_index, r_out.data_byte};
    assign o_m_axis_tuser  = {r_out.is_receive_packet, r_out.event_res};

    // An escape is only pending inside a frame.
    a_escape_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.escape_pending |-> r_state.position != POS_HUNT)
        else $error("escape pending while hunting");

    // In the payload the length is non-zero and the position never passes
    // the checksum byte.
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.position >= POS_PAYLOAD |->
            (r_state.frame_length != 16'h0000) &&
            (r_state.position <= {1'b0, r_state.frame_length} + POS_TYPE))
        else $error("payload position out of range");

    // A start byte taken while hunting opens a frame.
    a_start_opens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer && r_state.position == POS_HUNT && i_s_axis_tdata == START_MARK
        |=> r_state.position == POS_LEN_HI && !r_state.escape_pending)
        else $error("start byte did not open a frame");

    // A byte taken while hunting never gives a result.
    a_hunt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer && r_state.position == POS_HUNT |=> !o_m_axis_tvalid)
        else $error("result produced while hunting");

    // Only good frames can be flagged as receive packets.
    a_rx_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.is_receive_packet |-> r_out.event_res == EV_GOOD)
        else $error("receive flag on a non-good event");

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Escaped API frame receiver testbench
// Streams raw serial bytes into the receiver and checks each result transfer
// against a byte-level parser model kept in the testbench. A short table of
// directed bytes comes first, then random frames, broken frames and line noise
// over four phases of source idling and sink back-pressure, each phase with
// its own receive frame type setting.
// ----------------------------------------------------------------------------
module tb
    import eafr_pkg::*;
();

    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned PHASE_ITEMS   = 120;
    localparam int unsigned N_PHASES      = 4;
    localparam int unsigned N_DIRECTED    = 25;

    // Idling per phase: none, source only, sink only, both.
    localparam int unsigned SRC_IDLE_PCT [N_PHASES]  = '{0, 61, 0, 34};
    localparam int unsigned SINK_STALL_PCT [N_PHASES] = '{0, 0, 61, 34};

    // One directed byte; where typed is set, the expectation is written out.
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       typed;
        logic       has_res;
        t_result    res;
    } t_dir_row;

    localparam t_result NO_RESULT = '{EV_PAYLOAD, 8'h00, 16'h0000, 8'h00, 1'b0};

    localparam t_dir_row DIRECTED [N_DIRECTED] = '{
        // Hunting: ordinary bytes and escapes are dropped.
        '{8'h00, 1'b1, 1'b0, NO_RESULT},
        '{8'h7D, 1'b1, 1'b0, NO_RESULT},
        '{8'h7E, 1'b1, 1'b0, NO_RESULT},
        // Zero length frame.
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b1, 1'b1, '{EV_ZERO_LENGTH, 8'h00, 16'h0000, 8'h00, 1'b0}},
        // Good receive packet with an escaped length, an escaped escape
        // byte and an escape after an escape.
        '{8'h7E, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'h7D, 1'b0, 1'b0, NO_RESULT},
        '{8'h23, 1'b0, 1'b0, NO_RESULT},
        '{8'h90, 1'b0, 1'b0, NO_RESULT},
        '{8'h7D, 1'b0, 1'b0, NO_RESULT},
        '{8'h5D, 1'b1, 1'b1, '{EV_PAYLOAD, 8'h7D, 16'h0000, 8'h90, 1'b0}},
        '{8'h7D, 1'b0, 1'b0, NO_RESULT},
        '{8'h7D, 1'b1, 1'b1, '{EV_PAYLOAD, 8'h5D, 16'h0001, 8'h90, 1'b0}},
        '{8'h95, 1'b1, 1'b1, '{EV_GOOD, 8'h00, 16'h0000, 8'h90, 1'b1}},
        // Start mark straight after an escape, before the type is known.
        '{8'h7E, 1'b0, 1'b0, NO_RESULT},
        '{8'h7D, 1'b0, 1'b0, NO_RESULT},
        '{8'h7E, 1'b1, 1'b1, '{EV_START_IN_FRAME, 8'h00, 16'h0000, 8'h00, 1'b0}},
        // All-ones type and payload with a bad checksum.
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'h02, 1'b0, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, 1'b0, NO_RESULT},
        '{8'hFF, 1'b1, 1'b1, '{EV_PAYLOAD, 8'hFF, 16'h0000, 8'hFF, 1'b0}},
        '{8'h00, 1'b1, 1'b1, '{EV_BAD_SUM, 8'h00, 16'h0000, 8'hFF, 1'b0}},
        // Two start marks in a row.
        '{8'h7E, 1'b0, 1'b0, NO_RESULT},
        '{8'h7E, 1'b1, 1'b1, '{EV_START_IN_FRAME, 8'h00, 16'h0000, 8'h00, 1'b0}}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [7:0]  i_cfg_wr_data;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [31:0] o_m_axis_tdata;
    logic [3:0]  o_m_axis_tuser;

    // Parser model state and its copy of the receive frame type register.
    t_state      parser_st;
    logic [7:0]  rx_frame_type;

    t_result     expected_results [$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    int unsigned src_idle_pct   = 0;
    int unsigned sink_stall_pct = 0;

    escaped_api_frame_receiver_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Clear the per-frame state on a start mark.
    function automatic void open_frame();
        parser_st.position       = POS_LEN_HI;
        parser_st.running_sum    = 8'h00;
        parser_st.escape_pending = 1'b0;
        parser_st.current_type   = 8'h00;
    endfunction

    // Advance the parser model by one raw byte; returns 1 when a result is due.
    function automatic bit parse_byte(input logic [7:0] raw, output t_result res);
        logic [7:0] c;
        res = NO_RESULT;
        if (parser_st.position == POS_HUNT) begin
            if (raw == START_MARK) begin
                open_frame();
            end
            return 1'b0;
        end
        if (raw == START_MARK) begin
            res.event_res  = EV_START_IN_FRAME;
            res.frame_type = parser_st.current_type;
            open_frame();
            return 1'b1;
        end
        if (parser_st.escape_pending) begin
            c = raw ^ ESCAPE_FLIP;
            parser_st.escape_pending = 1'b0;
        end else if (raw == ESCAPE_MARK) begin
            parser_st.escape_pending = 1'b1;
            return 1'b0;
        end else begin
            c = raw;
        end
        case (parser_st.position)
            POS_LEN_HI: begin
                parser_st.frame_length = {c, 8'h00};
                parser_st.position     = POS_LEN_LO;
                return 1'b0;
            end
            POS_LEN_LO: begin
                parser_st.frame_length = {parser_st.frame_length[15:8], c};
                if (parser_st.frame_length == 16'h0000) begin
                    parser_st.position = POS_HUNT;
                    res.event_res      = EV_ZERO_LENGTH;
                    res.frame_type     = parser_st.current_type;
                    return 1'b1;
                end
                parser_st.position = POS_TYPE;
                return 1'b0;
            end
            POS_TYPE: begin
                parser_st.current_type = c;
                parser_st.running_sum  = c;
                parser_st.position     = POS_PAYLOAD;
                return 1'b0;
            end
            default: begin
                parser_st.running_sum = parser_st.running_sum + c;
                res.frame_type        = parser_st.current_type;
                if (parser_st.position >= {1'b0, parser_st.frame_length} + 17'd3) begin
                    res.event_res = (parser_st.running_sum == SUM_GOOD) ? EV_GOOD
                                                                         : EV_BAD_SUM;
                    res.is_receive_packet = (parser_st.running_sum == SUM_GOOD)
                                            && (parser_st.current_type == rx_frame_type);
                    parser_st.position = POS_HUNT;
                end else begin
                    res.data_byte  = c;
                    res.byte_index = 16'(parser_st.position - POS_PAYLOAD);
                    parser_st.position = parser_st.position + 17'd1;
                end
                return 1'b1;
            end
        endcase
    endfunction

    function automatic t_dir_row plain_row(input logic [7:0] b);
        t_dir_row row;
        row         = '0;
        row.rx_byte = b;
        row.res     = NO_RESULT;
        return row;
    endfunction

    // Offer one byte, with random source gaps, and log its expectation once
    // the transfer has happened.
    task automatic send_byte(input t_dir_row row);
        t_result predicted;
        bit      produces;
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= row.rx_byte;
        @(posedge i_clk);
        while (!o_s_axis_tready) begin
            @(posedge i_clk);
        end
        produces = parse_byte(row.rx_byte, predicted);
        if (row.typed) begin
            produces  = row.has_res;
            predicted = row.res;
        end
        if (produces) begin
            expected_results.push_back(predicted);
        end
    endtask

    // Hold the source off until every result is in, then let the receiver settle.
    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Build one frame, escape it and send it, whole or cut short.
    task automatic send_frame(input bit truncate, input bit zero_len,
                              output int unsigned n_sent);
        logic [7:0]  body [$];
        logic [7:0]  line [$];
        logic [15:0] len;
        logic [7:0]  sum;
        logic [7:0]  b;
        body = {};
        line = {};
        if (zero_len) begin
            len = 16'h0000;
        end else if ($urandom_range(39) == 0) begin
            len = 16'($urandom_range(300, 256));
        end else begin
            len = 16'($urandom_range(24, 1));
        end
        body.push_back(len[15:8]);
        body.push_back(len[7:0]);
        if (!zero_len) begin
            b   = $urandom_range(1) ? rx_frame_type : 8'($urandom);
            sum = b;
            body.push_back(b);
            for (int unsigned k = 1; k < len; k++) begin
                if ($urandom_range(7) == 0) begin
                    b = $urandom_range(1) ? START_MARK : ESCAPE_MARK;
                end else begin
                    b = 8'($urandom);
                end
                sum = sum + b;
                body.push_back(b);
            end
            b = SUM_GOOD - sum;
            if ($urandom_range(4) == 0) begin
                b = b + 8'($urandom_range(255, 1));
            end
            body.push_back(b);
        end
        // Framing bytes must be escaped; other bytes are escaped now and then,
        // except the one whose escaped form would be a start mark.
        line.push_back(START_MARK);
        foreach (body[k]) begin
            if (body[k] == START_MARK || body[k] == ESCAPE_MARK
                || (body[k] != (START_MARK ^ ESCAPE_FLIP) && $urandom_range(15) == 0)) begin
                line.push_back(ESCAPE_MARK);
                line.push_back(body[k] ^ ESCAPE_FLIP);
            end else begin
                line.push_back(body[k]);
            end
        end
        n_sent = truncate ? $urandom_range(line.size() - 1, 1) : line.size();
        for (int unsigned k = 0; k < n_sent; k++) begin
            send_byte(plain_row(line[k]));
        end
    endtask

    // Sink back-pressure.
    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Check every result transfer against the oldest expectation.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_results.size() == 0) begin
                $error("result with none expected: tdata %h tuser %h",
                       o_m_axis_tdata, o_m_axis_tuser);
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                if (o_m_axis_tuser[2:0] !== want.event_res) begin
                    $error("event_res: expected %0d, got %0d",
                           want.event_res, o_m_axis_tuser[2:0]);
                    mismatch_count++;
                end
                if (o_m_axis_tdata[7:0] !== want.data_byte) begin
                    $error("data_byte: expected %h, got %h",
                           want.data_byte, o_m_axis_tdata[7:0]);
                    mismatch_count++;
                end
                if (o_m_axis_tdata[23:8] !== want.byte_index) begin
                    $error("byte_index: expected %0d, got %0d",
                           want.byte_index, o_m_axis_tdata[23:8]);
                    mismatch_count++;
                end
                if (o_m_axis_tdata[31:24] !== want.frame_type) begin
                    $error("frame_type: expected %h, got %h",
                           want.frame_type, o_m_axis_tdata[31:24]);
                    mismatch_count++;
                end
                if (o_m_axis_tuser[3] !== want.is_receive_packet) begin
                    $error("is_receive_packet: expected %b, got %b",
                           want.is_receive_packet, o_m_axis_tuser[3]);
                    mismatch_count++;
                end
            end
        end
    end

    // Run time limit.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Stimulus.
    initial begin
        int unsigned items;
        int unsigned n_sent;
        int unsigned pick;
        logic [7:0]  cfg_value;
        i_rst_n         <= 1'b0;
        i_cfg_wr_en     <= 1'b0;
        i_cfg_wr_data   <= 8'h00;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= 8'h00;
        i_m_axis_tready <= 1'b0;
        parser_st       = '0;
        rx_frame_type   = RX_TYPE_RST;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed bytes under the reset value of the receive frame type.
        for (int unsigned k = 0; k < N_DIRECTED; k++) begin
            send_byte(DIRECTED[k]);
        end

        for (int unsigned phase = 0; phase < N_PHASES; phase++) begin
            wait_drained();
            cfg_value       = (phase == 2) ? 8'($urandom)
                                           : ((phase == 0) ? 8'h00
                                              : ((phase == 1) ? 8'hFF : RX_TYPE_RST));
            i_cfg_wr_en     <= 1'b1;
            i_cfg_wr_data   <= cfg_value;
            @(posedge i_clk);
            i_cfg_wr_en     <= 1'b0;
            rx_frame_type   = cfg_value;
            src_idle_pct    = SRC_IDLE_PCT[phase];
            sink_stall_pct  = SINK_STALL_PCT[phase];

            // Mostly well-formed frames; the rest truncated or zero-length frames, noise and drain pauses.
            items = 0;
            while (items < PHASE_ITEMS) begin
                pick = $urandom_range(99);
                if (pick < 70) begin
                    send_frame(1'b0, 1'b0, n_sent);
                end else if (pick < 80) begin
                    send_frame(1'b1, 1'b0, n_sent);
                end else if (pick < 85) begin
                    send_frame(1'b0, 1'b1, n_sent);
                end else if (pick < 95) begin
                    repeat ($urandom_range(6, 1)) send_byte(plain_row(8'($urandom)));
                    n_sent = 0;
                end else begin
                    wait_drained();
                    n_sent = 0;
                end
                items += n_sent;
            end
        end

        wait_drained();
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
